[sv/neighbour_colour_cooccurrence_core_defines.svh]
// Assertion macros shared by the checker of the colour co-occurrence core.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NEIGHBOUR_COLOUR_COOCCURRENCE_CORE_DEFINES_SVH
`define NEIGHBOUR_COLOUR_COOCCURRENCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ncc_pkg.sv]
// Shared types, constants and the pixel weight table of the co-occurrence core.
// No dependencies; every other RTL file but the queue refers to it by scoped names.
package ncc_pkg;

  // Default configuration of the core.
  localparam int unsigned NCC_COLORS      = 256;
  localparam int unsigned NCC_COUNT_BITS  = 24;
  localparam int unsigned NCC_QUEUE_DEPTH = 4;

  // Fixed result widths.
  localparam int unsigned NCC_FIT_W   = 17;
  localparam int unsigned NCC_FRAME_W = 40;
  localparam int unsigned NCC_PAIR_W  = 24;
  localparam int unsigned NCC_DIST_W  = 17;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_LEARN = 2'd0,
    CMD_SCORE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Kind of a queue entry: one table access, or the close of an item.
  typedef enum logic {
    OP_PAIR = 1'b0,
    OP_END  = 1'b1
  } op_kind_e;

  // Control part of a queue entry; the table address travels beside it.
  typedef struct packed {
    op_kind_e    kind;
    cmd_e        cmd;
    logic [3:0]  nb_total;
    logic        last;
  } op_info_t;

  // Pixel weight floor(65536 / n) in Q1.16 for n valid neighbours.
  function automatic logic [NCC_FIT_W-1:0] pixel_weight(input logic [3:0] n);
    logic [NCC_FIT_W-1:0] w;
    case (n)
      4'd1:    w = 17'd65536;
      4'd2:    w = 17'd32768;
      4'd3:    w = 17'd21845;
      4'd4:    w = 17'd16384;
      4'd5:    w = 17'd13107;
      4'd6:    w = 17'd10922;
      4'd7:    w = 17'd9362;
      4'd8:    w = 17'd8192;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

[sv/ncc_front.sv]
// Front end: accepts an item, classifies its neighbours and emits one table
// access per usable pair, then a closing entry. Depends on ncc_pkg.
module ncc_front #(
  parameter int unsigned COLORS = ncc_pkg::NCC_COLORS,
  parameter int unsigned ADDR_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            command_i,
  input  logic [7:0]            center_i,
  input  logic [7:0][7:0]       nb_i,
  input  logic [7:0]            valid_i,
  input  logic                  last_i,
  input  logic                  full_i,
  output logic                  push_o,
  output ncc_pkg::op_info_t     info_o,
  output logic [ADDR_W-1:0]     addr_o,
  output logic                  active_o
);

  typedef enum logic [1:0] {
    FE_IDLE = 2'b01,
    FE_EMIT = 2'b10
  } fe_state_e;

  fe_state_e          state_q, state_d;
  logic [7:0]         mask_q, mask_d;
  logic [7:0]         center_q;
  logic [7:0][7:0]    nb_q;
  ncc_pkg::cmd_e      cmd_q;
  logic [3:0]         total_q;
  logic               last_q;

  logic               ctr_ok;
  logic [7:0]         nb_ok;
  logic [3:0]         popcnt;
  logic [7:0]         mask_in;
  logic [3:0]         total_in;
  ncc_pkg::cmd_e      cmd_in;
  logic [2:0]         sel;
  logic [31:0]        addr_full;

  // Classify the incoming item: which pairs index the table.
  always_comb begin
    cmd_in = ncc_pkg::cmd_e'(command_i);
    ctr_ok = 32'(center_i) < COLORS;
    popcnt = '0;
    for (int k = 0; k < 8; k++) begin
      nb_ok[k] = 32'(nb_i[k]) < COLORS;
      popcnt   = popcnt + 4'(valid_i[k]);
    end
    case (cmd_in)
      ncc_pkg::CMD_LEARN, ncc_pkg::CMD_SCORE: begin
        mask_in  = valid_i & nb_ok & {8{ctr_ok}};
        total_in = popcnt;
      end
      ncc_pkg::CMD_READ: begin
        mask_in  = {7'd0, ctr_ok & nb_ok[0]};
        total_in = 4'd0;
      end
      default: begin
        mask_in  = 8'd0;
        total_in = 4'd0;
      end
    endcase
  end

  // Pick the lowest pending neighbour and form its table address.
  always_comb begin
    sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel = 3'(k);
      end
    end
    addr_full = 32'(center_q) * 32'(COLORS) + 32'(nb_q[sel]);
  end

  assign addr_o          = addr_full[ADDR_W-1:0];
  assign push_o          = (state_q == FE_EMIT) && !full_i;
  assign info_o.kind     = (mask_q != 8'd0) ? ncc_pkg::OP_PAIR : ncc_pkg::OP_END;
  assign info_o.cmd      = cmd_q;
  assign info_o.nb_total = total_q;
  assign info_o.last     = last_q;
  assign active_o        = (state_q == FE_EMIT);

  // Sequencer: load on accept, drain one entry per cycle into the queue while it is not full.
  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    case (state_q)
      FE_IDLE: begin
        if (accept_i) begin
          state_d = FE_EMIT;
          mask_d  = mask_in;
        end
      end
      FE_EMIT: begin
        if (!full_i) begin
          if (mask_q != 8'd0) begin
            mask_d = mask_q & ~(8'd1 << sel);
          end else begin
            state_d = FE_IDLE;
          end
        end
      end
      default: begin
        state_d = FE_IDLE;
        mask_d  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      mask_q  <= 8'd0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
    end
  end

  // Item payload, captured on accept.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      center_q <= center_i;
      nb_q     <= nb_i;
      cmd_q    <= cmd_in;
      total_q  <= total_in;
      last_q   <= last_i;
    end
  end

endmodule

[sv/ncc_queue.sv]
// Short first-in first-out queue between the front and back ends.
// No package dependencies; entry width and depth come from parameters.
module ncc_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned W     = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rptr_q];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[sv/ncc_back.sv]
// Back end: pair-count memory with read-modify-write pipeline, clearing pass,
// distinct pair total, frame accumulator and result registers. Uses ncc_pkg.
module ncc_back #(
  parameter int unsigned COLORS     = ncc_pkg::NCC_COLORS,
  parameter int unsigned COUNT_BITS = ncc_pkg::NCC_COUNT_BITS,
  parameter int unsigned ADDR_W     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              empty_i,
  input  ncc_pkg::op_info_t                 head_info_i,
  input  logic [ADDR_W-1:0]                 head_addr_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              done_o,
  output logic [3:0]                        match_count_o,
  output logic [3:0]                        neighbor_total_o,
  output logic [ncc_pkg::NCC_FIT_W-1:0]     pixel_fitness_o,
  output logic [ncc_pkg::NCC_FRAME_W-1:0]   frame_fitness_o,
  output logic                              frame_done_o,
  output logic [ncc_pkg::NCC_PAIR_W-1:0]    pair_count_o,
  output logic [ncc_pkg::NCC_DIST_W-1:0]    distinct_pairs_o
);

  localparam int unsigned DEPTH   = COLORS * COLORS;
  localparam int unsigned FIT_W   = ncc_pkg::NCC_FIT_W;
  localparam int unsigned FRAME_W = ncc_pkg::NCC_FRAME_W;
  localparam int unsigned PAIR_W  = ncc_pkg::NCC_PAIR_W;
  localparam int unsigned DIST_W  = ncc_pkg::NCC_DIST_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [DIST_W-1:0]     DIST_MAX = '1;
  localparam logic [FRAME_W-1:0]    FRAME_MAX = '1;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'b01,
    BK_RUN   = 2'b10
  } bk_state_e;

  bk_state_e                state_q;
  logic [ADDR_W-1:0]        clr_cnt_q;
  logic                     cfg_new_q;

  logic [COUNT_BITS-1:0]    mem_q [DEPTH];
  logic [COUNT_BITS-1:0]    rd_data_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [COUNT_BITS-1:0]    mem_wdata;

  logic                     s1_vld_q;
  ncc_pkg::op_info_t        s1_info_q;
  logic [ADDR_W-1:0]        s1_addr_q;

  logic                     fwd_vld_q;
  logic [ADDR_W-1:0]        fwd_addr_q;
  logic [COUNT_BITS-1:0]    fwd_data_q;

  logic [3:0]               matches_q;
  logic [PAIR_W-1:0]        pair_q;
  logic [DIST_W-1:0]        distinct_q;
  logic [FRAME_W-1:0]       acc_q;

  logic                     s2_vld_q;
  ncc_pkg::op_info_t        s2_info_q;
  logic [FIT_W-1:0]         s2_fit_q;
  logic [3:0]               s2_match_q;
  logic [PAIR_W-1:0]        s2_pair_q;

  logic [COUNT_BITS-1:0]    cur_val;
  logic [COUNT_BITS-1:0]    new_val;
  logic [31:0]              cur_wide;
  logic                     s1_pair, s1_end, s1_learn, s1_score, s1_read;
  logic [20:0]              fit_full;
  logic [FRAME_W:0]         acc_sum;
  logic [FRAME_W-1:0]       acc_new;
  logic                     s2_score;

  assign clearing_o = (state_q == BK_CLEAR);
  assign pop_o      = (state_q == BK_RUN) && !empty_i;

  // Count value seen by the access in stage one, with write forwarding.
  always_comb begin
    cur_val  = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data_q;
    new_val  = (cur_val == CNT_MAX) ? cur_val : cur_val + COUNT_BITS'(1);
    cur_wide = 32'(cur_val);
    s1_pair  = s1_vld_q && (s1_info_q.kind == ncc_pkg::OP_PAIR);
    s1_end   = s1_vld_q && (s1_info_q.kind == ncc_pkg::OP_END);
    s1_learn = s1_pair && (s1_info_q.cmd == ncc_pkg::CMD_LEARN);
    s1_score = s1_pair && (s1_info_q.cmd == ncc_pkg::CMD_SCORE);
    s1_read  = s1_pair && (s1_info_q.cmd == ncc_pkg::CMD_READ);
    fit_full = 21'(matches_q) * 21'(ncc_pkg::pixel_weight(s1_info_q.nb_total));
  end

  // The single write port serves the clearing pass and learn updates.
  always_comb begin
    mem_we    = clearing_o || s1_learn;
    mem_waddr = clearing_o ? clr_cnt_q : s1_addr_q;
    mem_wdata = clearing_o ? '0 : new_val;
  end

  // Pair-count memory with a registered read of the queue head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[head_addr_i];
  end

  // Sequencer for the clearing pass and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
      cfg_new_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        cfg_new_q <= cfg_wdata_i;
      end
      case (state_q)
        BK_CLEAR: begin
          if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= BK_RUN;
          end
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
        end
        BK_RUN: begin
          state_q <= BK_RUN;
        end
        default: begin
          state_q <= BK_CLEAR;
        end
      endcase
    end
  end

  // Stage one and per-item tallies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      matches_q  <= '0;
      pair_q     <= '0;
      distinct_q <= '0;
      s2_vld_q   <= 1'b0;
    end else begin
      s1_vld_q <= pop_o;
      s2_vld_q <= s1_end;
      if (s1_learn) begin
        fwd_vld_q <= 1'b1;
      end
      if (s1_learn && (cur_val == '0) && cfg_new_q && (distinct_q != DIST_MAX)) begin
        distinct_q <= distinct_q + DIST_W'(1);
      end
      if (s1_end) begin
        matches_q <= '0;
        pair_q    <= '0;
      end else begin
        if (s1_score && (cur_val != '0)) begin
          matches_q <= matches_q + 4'd1;
        end
        if (s1_read) begin
          pair_q <= cur_wide[PAIR_W-1:0];
        end
      end
    end
  end

  // Stage payloads: queue head, forwarding copy, closing snapshot.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_info_q <= head_info_i;
      s1_addr_q <= head_addr_i;
    end
    if (s1_learn) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_val;
    end
    if (s1_end) begin
      s2_info_q  <= s1_info_q;
      s2_fit_q   <= fit_full[FIT_W-1:0];
      s2_match_q <= matches_q;
      s2_pair_q  <= pair_q;
    end
  end

  // Frame total with saturation.
  always_comb begin
    s2_score = (s2_info_q.cmd == ncc_pkg::CMD_SCORE);
    acc_sum  = {1'b0, acc_q} + (FRAME_W + 1)'(s2_fit_q);
    acc_new  = acc_sum[FRAME_W] ? FRAME_MAX : acc_sum[FRAME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= s2_vld_q;
      if (s2_vld_q && s2_score) begin
        acc_q <= s2_info_q.last ? '0 : acc_new;
      end
    end
  end

  // Result registers, shown for one cycle under the done strobe.
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      match_count_o    <= s2_score ? s2_match_q : 4'd0;
      neighbor_total_o <= s2_info_q.nb_total;
      pixel_fitness_o  <= s2_score ? s2_fit_q : '0;
      frame_fitness_o  <= (s2_score && s2_info_q.last) ? acc_new : '0;
      frame_done_o     <= s2_score && s2_info_q.last;
      pair_count_o     <= (s2_info_q.cmd == ncc_pkg::CMD_READ) ? s2_pair_q : '0;
      distinct_pairs_o <= distinct_q;
    end
  end

endmodule

[sv/neighbour_colour_cooccurrence_core.sv]
// The closing entry of an item passes the queue, stage one and stage two before the done strobe.
// The front end issues one pair access per cycle while the queue is not full, to the single
// read-modify-write port of the pair-count memory; it takes a new item only once it is idle again.
// The receiver cannot stall; the done strobe marks each result for one cycle.
// Reset is asynchronous and active low; afterwards a clearing pass writes zero to all
// COLORS*COLORS entries (65536 by default) of the memory while busy_o stays high.
module neighbour_colour_cooccurrence_core #(
  parameter int unsigned COLORS      = ncc_pkg::NCC_COLORS,
  parameter int unsigned COUNT_BITS  = ncc_pkg::NCC_COUNT_BITS,
  parameter int unsigned QUEUE_DEPTH = ncc_pkg::NCC_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  output logic                              done_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic [1:0]                        command_i,
  input  logic [7:0]                        center_color_i,
  input  logic [7:0]                        neighbor_0_i,
  input  logic [7:0]                        neighbor_1_i,
  input  logic [7:0]                        neighbor_2_i,
  input  logic [7:0]                        neighbor_3_i,
  input  logic [7:0]                        neighbor_4_i,
  input  logic [7:0]                        neighbor_5_i,
  input  logic [7:0]                        neighbor_6_i,
  input  logic [7:0]                        neighbor_7_i,
  input  logic [7:0]                        neighbor_valid_i,
  input  logic                              last_of_frame_i,
  output logic [3:0]                        match_count_o,
  output logic [3:0]                        neighbor_total_o,
  output logic [ncc_pkg::NCC_FIT_W-1:0]     pixel_fitness_o,
  output logic [ncc_pkg::NCC_FRAME_W-1:0]   frame_fitness_o,
  output logic                              frame_done_o,
  output logic [ncc_pkg::NCC_PAIR_W-1:0]    pair_count_o,
  output logic [ncc_pkg::NCC_DIST_W-1:0]    distinct_pairs_o
);

  localparam int unsigned ADDR_W  = $clog2(COLORS * COLORS);
  localparam int unsigned INFO_W  = $bits(ncc_pkg::op_info_t);
  localparam int unsigned ENTRY_W = INFO_W + ADDR_W;

  logic                   accept;
  logic                   front_active;
  logic                   clearing;
  logic [7:0][7:0]        nb;
  logic                   push, pop, full, empty;
  ncc_pkg::op_info_t      push_info, head_info;
  logic [ADDR_W-1:0]      push_addr, head_addr;
  logic [ENTRY_W-1:0]     q_wdata, q_rdata;

  // An item is taken when the front end is free and the memory is cleared.
  assign busy_o = clearing || front_active;
  assign accept = start_i && !busy_o;

  assign nb = {neighbor_7_i, neighbor_6_i, neighbor_5_i, neighbor_4_i,
               neighbor_3_i, neighbor_2_i, neighbor_1_i, neighbor_0_i};

  ncc_front #(
    .COLORS (COLORS),
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .command_i(command_i),
    .center_i (center_color_i),
    .nb_i     (nb),
    .valid_i  (neighbor_valid_i),
    .last_i   (last_of_frame_i),
    .full_i   (full),
    .push_o   (push),
    .info_o   (push_info),
    .addr_o   (push_addr),
    .active_o (front_active)
  );

  // Queue entries carry the control fields above the table address.
  assign q_wdata   = {push_info, push_addr};
  assign head_info = ncc_pkg::op_info_t'(q_rdata[ENTRY_W-1:ADDR_W]);
  assign head_addr = q_rdata[ADDR_W-1:0];

  ncc_queue #(
    .DEPTH (QUEUE_DEPTH),
    .W     (ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (full),
    .empty_o(empty)
  );

  ncc_back #(
    .COLORS     (COLORS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .empty_i         (empty),
    .head_info_i     (head_info),
    .head_addr_i     (head_addr),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .done_o          (done_o),
    .match_count_o   (match_count_o),
    .neighbor_total_o(neighbor_total_o),
    .pixel_fitness_o (pixel_fitness_o),
    .frame_fitness_o (frame_fitness_o),
    .frame_done_o    (frame_done_o),
    .pair_count_o    (pair_count_o),
    .distinct_pairs_o(distinct_pairs_o)
  );

endmodule

[sv/ncc_checker.sv]
// Port-level checker for the co-occurrence core, bound to the top level.
// Depends on ncc_pkg and the assertion macros of the defines header.
`include "neighbour_colour_cooccurrence_core_defines.svh"

module ncc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic [3:0]                        match_count_o,
  input logic [3:0]                        neighbor_total_o,
  input logic [ncc_pkg::NCC_FRAME_W-1:0]   frame_fitness_o,
  input logic                              frame_done_o
);

  // An accepted item occupies the front end in the following cycle.
  `NCC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accept without busy")

  // The front end takes no item while it emits the last, so results never come back to back.
  `NCC_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "done strobe held")

  // Matches are counted only among valid neighbours.
  `NCC_ASSERT_IMP(a_match_le_total, clk_i, rst_ni, done_o, match_count_o <= neighbor_total_o, "match count exceeds neighbours")

  // A frame total is shown only with the frame-done flag.
  `NCC_ASSERT_IMP(a_frame_zero, clk_i, rst_ni, done_o && !frame_done_o, frame_fitness_o == '0, "frame total without frame done")

endmodule

bind neighbour_colour_cooccurrence_core ncc_checker u_checker (.*);
